// File: hw/rtl/lmsc_pkg.sv
// Shared types and constants for the letter multiset spell check block.
// No dependencies; imported by all lmsc modules and the top level.
package lmsc_pkg;

  localparam int PHRASE_MAX_DEF = 16;   // default phrase capacity
  localparam int CHAR_W         = 8;
  localparam int PHRASE_BITS    = 16 * CHAR_W;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_INDEX_W    = 2;
  localparam int FOUND_W        = 5;
  localparam int LENGTH_W       = 8;
  localparam int VERDICT_W      = 2;
  localparam int USED_W         = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH     = 2'd2;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FULL    = 2'd0,
    VERDICT_PARTIAL = 2'd1,
    VERDICT_NONE    = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [FOUND_W-1:0]  found;
    logic [LENGTH_W-1:0] length;
    verdict_t            verdict;
    logic [USED_W-1:0]   used;
  } result_t;

endpackage

// File: hw/rtl/lmsc_match.sv
// Phrase position match: parallel byte compares and lowest-index pick.
// Depends on lmsc_pkg.
module lmsc_match #(
  parameter int PHRASE_MAX = lmsc_pkg::PHRASE_MAX_DEF
) (
  input  logic [lmsc_pkg::PHRASE_BITS-1:0] phrase,
  input  logic [4:0]                       phrase_length,
  input  logic [PHRASE_MAX-1:0]            used_mask,
  input  logic [lmsc_pkg::CHAR_W-1:0]      letter,
  output logic                             hit,
  output logic [PHRASE_MAX-1:0]            pick
);
  import lmsc_pkg::*;

  logic [4:0]            len_eff;
  logic [PHRASE_MAX-1:0] cand;

  // lengths above capacity act as full capacity
  assign len_eff = (phrase_length > 5'(PHRASE_MAX)) ? 5'(PHRASE_MAX) : phrase_length;

  always_comb begin
    for (int pos = 0; pos < PHRASE_MAX; pos++) begin
      cand[pos] = (5'(pos) < len_eff) && !used_mask[pos] &&
                  (phrase[pos*CHAR_W +: CHAR_W] == letter);
    end
  end

  // isolate lowest set bit
  assign pick = cand & (~cand + PHRASE_MAX'(1));
  assign hit  = |cand;

endmodule

// File: hw/rtl/lmsc_word_state.sv
// Per-word state: used mask, found and length counters, result formation.
// Depends on lmsc_pkg.
module lmsc_word_state #(
  parameter int PHRASE_MAX = lmsc_pkg::PHRASE_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    last,
  input  logic                    hit,
  input  logic [PHRASE_MAX-1:0]   pick,
  output logic [PHRASE_MAX-1:0]   used_mask,
  output lmsc_pkg::result_t       result
);
  import lmsc_pkg::*;

  logic [PHRASE_MAX-1:0] used_mask_next;
  logic [FOUND_W-1:0]    found_count;
  logic [FOUND_W-1:0]    found_count_next;
  logic [LENGTH_W-1:0]   length_count;
  logic [LENGTH_W-1:0]   length_count_next;
  logic [PHRASE_MAX-1:0] mask_upd;
  logic [FOUND_W-1:0]    found_upd;
  logic [LENGTH_W-1:0]   length_upd;

  assign mask_upd   = used_mask | pick;
  assign found_upd  = found_count + FOUND_W'(hit);
  assign length_upd = (length_count == '1) ? length_count : length_count + LENGTH_W'(1);

  always_comb begin
    result.found  = found_upd;
    result.length = length_upd;
    result.used   = USED_W'(mask_upd);
    if (LENGTH_W'(found_upd) == length_upd) begin
      result.verdict = VERDICT_FULL;
    end else if (found_upd != '0) begin
      result.verdict = VERDICT_PARTIAL;
    end else begin
      result.verdict = VERDICT_NONE;
    end
  end

  always_comb begin
    used_mask_next    = used_mask;
    found_count_next  = found_count;
    length_count_next = length_count;
    if (step) begin
      if (last) begin
        used_mask_next    = '0;
        found_count_next  = '0;
        length_count_next = '0;
      end else begin
        used_mask_next    = mask_upd;
        found_count_next  = found_upd;
        length_count_next = length_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_mask    <= '0;
      found_count  <= '0;
      length_count <= '0;
    end else begin
      used_mask    <= used_mask_next;
      found_count  <= found_count_next;
      length_count <= length_count_next;
    end
  end

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    step |-> $onehot0(pick))
    else $error("pick selects more than one position");

  a_pick_unused: assert property (@(posedge clk) disable iff (rst)
    step |-> ((pick & used_mask) == '0))
    else $error("pick hits a position already used");

  a_count_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(used_mask) == int'(found_count))
    else $error("found count disagrees with used mask");

endmodule

// File: hw/rtl/letter_multiset_spell_check_core.sv
// Letter multiset spell check: one letter per item, one result per word
// (on the item flagged last_letter). Each letter claims the lowest unused
// phrase position holding the same byte. An item is held in an input
// register; when it leaves it, the compare/pick and counter update load the
// result register, which holds a word's result once its last item leaves
// the input register. A new item is accepted every cycle; only a word-ending
// item waits, and only while the result register is full and stalled.
// The user must write configuration only while idle; the block does not enforce it.
// Depends on lmsc_pkg, lmsc_match, lmsc_word_state.
module letter_multiset_spell_check_core #(
  parameter int PHRASE_MAX = lmsc_pkg::PHRASE_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lmsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [lmsc_pkg::CHAR_W-1:0]        letter,
  input  logic                               last_letter,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lmsc_pkg::FOUND_W-1:0]       letters_found,
  output logic [lmsc_pkg::LENGTH_W-1:0]      word_length,
  output logic [lmsc_pkg::VERDICT_W-1:0]     verdict,
  output logic [lmsc_pkg::USED_W-1:0]        used_positions
);
  import lmsc_pkg::*;

  logic [CFG_DATA_W-1:0] chars_low;
  logic [CFG_DATA_W-1:0] chars_high;
  logic [4:0]            phrase_len;

  logic                  s1_valid;
  logic                  s1_valid_next;
  logic [CHAR_W-1:0]     s1_letter;
  logic                  s1_last;
  logic                  take;
  logic                  advance;
  logic                  out_valid_next;

  logic                  hit;
  logic [PHRASE_MAX-1:0] pick;
  logic [PHRASE_MAX-1:0] used_mask;
  result_t               result;
  result_t               out_reg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_low  <= '0;
      chars_high <= '0;
      phrase_len <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHARS_LOW:  chars_low  <= cfg_data;
        REG_CHARS_HIGH: chars_high <= cfg_data;
        REG_LENGTH:     phrase_len <= cfg_data[4:0];
        default:        ;
      endcase
    end
  end

  // non-last items need no result slot, so they never wait on the output
  assign advance  = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_next = s1_valid;
    if (take) begin
      s1_valid_next = 1'b1;
    end else if (advance) begin
      s1_valid_next = 1'b0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (advance && s1_last) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_letter <= letter;
      s1_last   <= last_letter;
    end
    if (advance && s1_last) begin
      out_reg <= result;
    end
  end

  lmsc_match #(
    .PHRASE_MAX(PHRASE_MAX)
  ) u_match (
    .phrase        ({chars_high, chars_low}),
    .phrase_length (phrase_len),
    .used_mask     (used_mask),
    .letter        (s1_letter),
    .hit           (hit),
    .pick          (pick)
  );

  lmsc_word_state #(
    .PHRASE_MAX(PHRASE_MAX)
  ) u_word_state (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .last      (s1_last),
    .hit       (hit),
    .pick      (pick),
    .used_mask (used_mask),
    .result    (result)
  );

  assign letters_found  = out_reg.found;
  assign word_length    = out_reg.length;
  assign verdict        = out_reg.verdict;
  assign used_positions = out_reg.used;

  a_found_le_length: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (FOUND_W'(letters_found) <= FOUND_W'(16)) &&
                  (LENGTH_W'(letters_found) <= word_length))
    else $error("more letters found than letters in word");

  a_full_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_FULL) |-> (LENGTH_W'(letters_found) == word_length))
    else $error("full verdict with unmatched letters");

  a_used_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(used_positions) == int'(letters_found)))
    else $error("used positions disagree with letters found");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench for letter_multiset_spell_check_core: random words against random phrases,
// checked per word by a scoreboard class that tracks phrase positions claimed so far.
// Depends on lmsc_pkg and the core RTL.
module tb;
  import lmsc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;  // no register here
  localparam int PHRASE_CAP    = PHRASE_MAX_DEF;
  localparam int ITEM_TARGET   = 1750;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int TIMEOUT_NS    = 4_000_000;

  class spell_scoreboard;
    logic [CFG_DATA_W-1:0] chars_low, chars_high;
    logic [4:0]            phrase_len;
    logic [USED_W-1:0]     used_mask;
    logic [FOUND_W-1:0]    found_count;
    logic [LENGTH_W-1:0]   length_count;
    result_t               words_due[$];
    int                    errors;

    function new();
      chars_low = '0;
      chars_high = '0;
      phrase_len = '0;
      used_mask = '0;
      found_count = '0;
      length_count = '0;
      errors = 0;
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    function void apply_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CHARS_LOW:  chars_low = data;
        REG_CHARS_HIGH: chars_high = data;
        REG_LENGTH:     phrase_len = data[4:0];
        default: ;
      endcase
    endfunction

    // claim the lowest free position holding ch; close the word on last
    function void note_letter(logic [CHAR_W-1:0] ch, logic last);
      int               limit;
      bit               hit;
      logic [CHAR_W-1:0] pc;
      result_t          r;
      limit = (int'(phrase_len) > PHRASE_CAP) ? PHRASE_CAP : int'(phrase_len);
      hit = 1'b0;
      for (int pos = 0; pos < limit; pos++) begin
        pc = (pos < 8) ? chars_low[8*pos +: 8] : chars_high[8*(pos-8) +: 8];
        if (!hit && !used_mask[pos] && pc == ch) begin
          used_mask[pos] = 1'b1;
          found_count++;
          hit = 1'b1;
        end
      end
      if (length_count != 8'hFF) length_count++;
      if (last) begin
        r.found = found_count;
        r.length = length_count;
        r.used = used_mask;
        if ({3'b000, found_count} == length_count) r.verdict = VERDICT_FULL;
        else if (found_count != 0) r.verdict = VERDICT_PARTIAL;
        else r.verdict = VERDICT_NONE;
        words_due.push_back(r);
        used_mask = '0;
        found_count = '0;
        length_count = '0;
      end
    endfunction

    function void report(string field, int want, int got);
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_word_result(logic [FOUND_W-1:0] f, logic [LENGTH_W-1:0] l,
                                    logic [VERDICT_W-1:0] v, logic [USED_W-1:0] u);
      result_t want;
      if (words_due.size() == 0) begin
        errors++;
        $error("word result with no word outstanding");
        return;
      end
      want = words_due.pop_front();
      if (f !== want.found) report("letters_found", want.found, f);
      if (l !== want.length) report("word_length", want.length, l);
      if (v !== want.verdict) report("verdict", want.verdict, v);
      if (u !== want.used) report("used_positions", want.used, u);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CHAR_W-1:0]      letter = '0;
  logic                   last_letter = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FOUND_W-1:0]     letters_found;
  logic [LENGTH_W-1:0]    word_length;
  logic [VERDICT_W-1:0]   verdict;
  logic [USED_W-1:0]      used_positions;

  spell_scoreboard sb;
  bit              calm = 1'b0;      // no gaps on either side
  bit              hold_req = 1'b0;  // ask the receiver for a long hold-off
  int              letters_sent = 0;
  logic [7:0]      cur_chars [16];
  int              cur_len = 0;

  letter_multiset_spell_check_core u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .letter, .last_letter,
    .out_valid, .out_stall, .letters_found, .word_length, .verdict, .used_positions
  );

  always #2 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.apply_write(cfg_index, cfg_data);
      if (out_valid && !out_stall)
        sb.check_word_result(letters_found, word_length, verdict, used_positions);
      if (in_valid && !in_stall) sb.note_letter(letter, last_letter);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int eff_len();
    return (cur_len > PHRASE_CAP) ? PHRASE_CAP : cur_len;
  endfunction

  // receiver
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        stall_left = HOLD_CYCLES - 1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        g = pick_gap();
        out_stall <= (g != 0);
        if (g != 0) stall_left = g - 1;
      end
    end
  end

  task automatic send_letter(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    letter <= ch;
    last_letter <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    letters_sent++;
  endtask

  // letters mostly drawn from the phrase, the rest arbitrary bytes
  task automatic send_word(input int n);
    logic [7:0] ch;
    int         eff;
    eff = eff_len();
    for (int i = 0; i < n; i++) begin
      if (eff > 0 && $urandom_range(0, 9) < 7) ch = cur_chars[$urandom_range(0, eff - 1)];
      else ch = 8'($urandom_range(0, 255));
      send_letter(ch, i == n - 1);
    end
  endtask

  // the whole phrase in shuffled order
  task automatic send_anagram();
    int order [16];
    int eff;
    int j;
    int t;
    eff = eff_len();
    if (eff == 0) begin
      send_letter(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    for (int i = 0; i < eff; i++) order[i] = i;
    for (int i = eff - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < eff; i++) send_letter(cur_chars[order[i]], i == eff - 1);
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_phrase(input int len);
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = cur_chars[i];
      hi[8*i +: 8] = cur_chars[i + 8];
    end
    cur_len = len;
    write_reg(REG_CHARS_LOW, lo);
    write_reg(REG_CHARS_HIGH, hi);
    write_reg(REG_LENGTH, CFG_DATA_W'(len));
  endtask

  task automatic pick_phrase();
    int         kind;
    int         r;
    logic [7:0] alphabet [4];
    alphabet = '{"a", "b", "c", "*"};
    kind = $urandom_range(0, 4);
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: cur_chars[i] = 8'($urandom_range(0, 255));
        1: cur_chars[i] = alphabet[$urandom_range(0, 3)];
        2: cur_chars[i] = 8'h00;
        3: cur_chars[i] = 8'hFF;
        default: cur_chars[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : "*";
      endcase
    end
    r = $urandom_range(0, 9);
    if (r == 0) load_phrase(0);
    else if (r == 1) load_phrase(16);
    else if (r == 2) load_phrase($urandom_range(17, 31));
    else load_phrase($urandom_range(1, 16));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
  endtask

  initial begin
    int phase;
    int n_words;
    int r;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phrase length still zero after reset: nothing can match
    send_letter("A", 1'b1);
    quiesce();

    cur_chars = '{"S", "P", "E", "L", "L", "*", 8'h00, 8'hFF,
                  "a", "b", "c", "a", "*", 8'h80, 8'h7F, 8'h01};
    load_phrase(16);
    send_letter("L", 1'b0);  // repeated letter takes the next free copy
    send_letter("L", 1'b0);
    send_letter("*", 1'b0);
    send_letter("S", 1'b1);
    send_letter(8'h00, 1'b0);
    send_letter(8'hFF, 1'b0);
    send_letter(8'h99, 1'b1);
    send_letter("*", 1'b0);  // two marker copies, third one misses
    send_letter("*", 1'b0);
    send_letter("*", 1'b1);
    quiesce();
    load_phrase(31);  // oversize length clamps to full phrase
    send_letter(8'h01, 1'b1);
    quiesce();
    write_reg(REG_UNUSED, '1);
    send_letter(8'h01, 1'b1);
    // phrase cut to nothing in the middle of a word; used mask survives
    send_letter("a", 1'b0);
    quiesce();
    cur_len = 0;
    write_reg(REG_LENGTH, '0);
    send_letter("a", 1'b1);

    phase = 0;
    while (letters_sent < ITEM_TARGET) begin
      quiesce();
      calm = (phase % 5 == 2);
      pick_phrase();
      if (phase == 3) begin
        // receiver holds off while single-letter words keep coming
        calm = 1'b1;
        send_word(1);
        hold_req = 1'b1;
        repeat (40) send_word(1);
        calm = 1'b0;
      end
      if (phase == 5 || phase == 17) send_word($urandom_range(256, 270));
      n_words = $urandom_range(6, 16);
      for (int w = 0; w < n_words; w++) begin
        r = $urandom_range(0, 9);
        if (r < 2) send_anagram();
        else if (r < 6) send_word($urandom_range(1, 4));
        else send_word($urandom_range(5, 20));
      end
      phase++;
    end

    quiesce();
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
